// File: design/tvh_pkg.sv
// Shared types, constants and a helper function of the three-variant hash.
package tvh_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [1:0] VAR_F = 2'd0;
  localparam logic [1:0] VAR_G = 2'd1;
  localparam logic [1:0] VAR_H = 2'd2;

  localparam logic [1:0] MODE_BUF  = 2'd0;
  localparam logic [1:0] MODE_PAD  = 2'd1;
  localparam logic [1:0] MODE_TAIL = 2'd2;

  localparam int BLOCK_BYTES = 80;
  localparam int BLOCK_WORDS = 20;
  localparam int ROUNDS      = 70;
  localparam int WIN_DEPTH   = 31;

  localparam logic [31:0] CARRY_HIGH_INIT = 32'h6F2DEC53;
  localparam logic [31:0] CARRY_LOW_INIT  = 32'hA4523B59;

  localparam logic [31:0] CHAIN_INIT [8] = '{
    32'hFE826539, 32'h93634602, 32'h4EF3D23A, 32'hCA7F833C,
    32'h70752CF1, 32'hADCBE99E, 32'h104C2B8F, 32'h3923261C
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h46E97E9A, 32'h1BCE81B6, 32'hBB8EFFB8, 32'hE4A2353E,
    32'hC07E77EB, 32'hB326E7D7, 32'hEF16CA66, 32'h493D7A1F,
    32'h76A8D32C, 32'h66FE81D1, 32'h5429A7BA, 32'h78EEF40B,
    32'hC69A78B0, 32'hF2C7DEF2, 32'hD09F33E8, 32'h8EDC5D7A,
    32'h8CF9EB54, 32'hEEE27FAD, 32'h67606050, 32'h7F2DD66F,
    32'h1751201E, 32'h9A48010B, 32'h9A2BEE62, 32'h35C7B6A6,
    32'hE7AF1E8E, 32'h00F25B18, 32'h5E9E0445, 32'h9E8666B5,
    32'h8E31E502, 32'h5946572C, 32'h4CCA2155, 32'h7BB503BC,
    32'hAD83A969, 32'hA6D2EB0C, 32'h749F44CB, 32'h60574AA3,
    32'h97B88D86, 32'hEE21E31F, 32'h059DF378, 32'hB9EA645C,
    32'h56727A7B, 32'h50F9EA81, 32'hC8B66202, 32'h54FCEF49,
    32'h657EA0F3, 32'hDB99936C, 32'h3B2687AC, 32'h3141F7CA,
    32'hE0825A6E, 32'hAC89F129, 32'hC9CAF1C8, 32'h0D507859,
    32'h28E068C2, 32'h078AAFC9, 32'hE0EA14D0, 32'hF1631487,
    32'h2DFBC84D, 32'h4E73FAFA, 32'h2455A0CA, 32'hDA4F47DB,
    32'hCCF6D828, 32'h2108321A, 32'h8CFD512F, 32'h9CA7AB20
  };

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] s);
    logic [5:0] r;
    r = 6'd32 - {1'b0, s};
    return (x << s) | (x >> r);
  endfunction

endpackage

// File: design/tvh_feed_if.sv
// Input channel of the hash: opcode and message byte.
interface tvh_feed_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

// File: design/tvh_digest_if.sv
// Output channel of the hash: one digest word per beat.
interface tvh_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// File: design/tvh_front.sv
// Front end: accepts input beats into a short queue for the compression engine.
module tvh_front #(
  parameter int Depth = 4
) (
  input  logic          clk,
  input  logic          rst,
  tvh_feed_if.sink      feed,
  output tvh_pkg::item_t head,
  output logic          head_valid,
  input  logic          pop
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  tvh_pkg::item_t slots [Depth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           take;

  assign feed.ready = (count != CW'(Depth));
  assign push       = feed.valid && feed.ready;
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: feed.op, data_byte: feed.data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// File: design/tvh_back.sv
// Back end: block buffer, 70-round compression engine and digest output.
module tvh_back (
  input  logic           clk,
  input  logic           rst,
  input  tvh_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  tvh_digest_if.source   digest
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_COMP = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t      state;
  logic [31:0] chain [8];
  logic [31:0] v     [8];
  logic [31:0] vn    [8];
  logic [31:0] u     [8];
  logic [31:0] chain_sum [8];
  logic [31:0] win   [tvh_pkg::WIN_DEPTH];
  logic [31:0] blk   [tvh_pkg::BLOCK_WORDS];
  logic [31:0] ch, cl, src_h, src_l;
  logic [6:0]  fill, fill_save, rnd;
  logic [63:0] len;
  logic [31:0] cnt;
  logic [1:0]  vsel, mode;
  logic        tail_pend, emit_pend;
  logic [2:0]  idx;

  logic [31:0] c1, c2, cnt_next;
  logic [1:0]  vsel_next;
  logic [1:0]  off;
  logic [6:0]  jfull;
  logic [4:0]  j;
  logic [31:0] bw, init_w, sched_w, wn;
  logic        hi;

  function automatic logic [31:0] wd(input int d);
    return win[d - 1];
  endfunction

  // variant pick: gap to next even-parity count
  always_comb begin
    c1 = cnt + 32'd1;
    c2 = cnt + 32'd2;
    if (!(^c1)) begin
      vsel_next = tvh_pkg::VAR_F;
      cnt_next  = c1;
    end else if (!(^c2)) begin
      vsel_next = tvh_pkg::VAR_G;
      cnt_next  = c2;
    end else begin
      vsel_next = tvh_pkg::VAR_H;
      cnt_next  = cnt + 32'd3;
    end
  end

  // message word for the current round
  always_comb begin
    case (vsel)
      tvh_pkg::VAR_F: off = 2'd0;
      tvh_pkg::VAR_G: off = 2'd2;
      default:        off = 2'd1;
    endcase
    jfull = rnd - {5'd0, off};
    j     = jfull[4:0];
    if (mode == tvh_pkg::MODE_TAIL) begin
      bw = tvh_pkg::rol(src_h, j) + src_l;
    end else begin
      bw = (j < 5'(tvh_pkg::BLOCK_WORDS)) ? blk[j] : '0;
      if (mode == tvh_pkg::MODE_PAD) begin
        for (int b = 0; b < 4; b++) begin
          if ({j, 2'(b)} >= fill_save) begin
            bw[31 - 8*b -: 8] = 8'd0;
          end
        end
      end
    end
    case (vsel)
      tvh_pkg::VAR_F: init_w = (rnd == 7'd20) ? ch : (rnd == 7'd21) ? cl : bw;
      tvh_pkg::VAR_G: init_w = (rnd == 7'd0) ? ch : (rnd == 7'd1) ? cl : bw;
      default:        init_w = (rnd == 7'd0) ? ch : (rnd == 7'd21) ? cl : bw;
    endcase
    hi = (rnd >= 7'd46);
    case (vsel)
      tvh_pkg::VAR_F: sched_w = hi ?
          tvh_pkg::rol(wd(1), 5'd9) + (wd(6) ^ wd(16) ^ wd(31)) +
          tvh_pkg::rol(wd(24) + wd(2), 5'd19) :
          tvh_pkg::rol(wd(1), 5'd7) + (wd(5) ^ wd(11) ^ wd(16)) +
          tvh_pkg::rol(wd(22) + wd(3), 5'd27);
      tvh_pkg::VAR_G: sched_w = hi ?
          tvh_pkg::rol(wd(1), 5'd7) + (wd(6) ^ wd(12) ^ wd(21)) +
          tvh_pkg::rol(wd(24) + wd(2), 5'd27) :
          tvh_pkg::rol(wd(1), 5'd23) + (wd(3) ^ wd(7) ^ wd(18)) +
          tvh_pkg::rol(wd(22) + wd(2), 5'd7);
      default: sched_w = hi ?
          tvh_pkg::rol(wd(24), 5'd13) + (wd(5) ^ wd(10) ^ wd(19)) +
          tvh_pkg::rol(wd(2) + wd(1), 5'd19) :
          tvh_pkg::rol(wd(2), 5'd29) + (wd(4) ^ wd(9) ^ wd(15)) +
          tvh_pkg::rol(wd(22) + wd(1), 5'd5);
    endcase
    wn = (rnd < 7'd22) ? init_w : sched_w;
  end

  // one round of the selected variant
  always_comb begin
    for (int i = 0; i < 8; i++) u[i] = v[i];
    case (vsel)
      tvh_pkg::VAR_F: begin
        u[1] = v[1] + v[0] + wn;
        u[0] = tvh_pkg::rol(v[0], 5'd3);
        u[2] = v[2] + tvh_pkg::ROUND_K[u[1][5:0]];
        u[3] = v[3] + u[0] + (tvh_pkg::rol(u[0], 5'd7) ^ tvh_pkg::rol(u[0], 5'd22));
        u[5] = v[5] + v[4] + wn;
        u[6] = v[6] + tvh_pkg::ROUND_K[wn[5:0]];
        u[7] = v[7] + (v[4] ^ (tvh_pkg::rol(v[4], 5'd13) + tvh_pkg::rol(v[4], 5'd27)));
      end
      tvh_pkg::VAR_G: begin
        u[1] = v[1] + v[0] + wn;
        u[2] = v[2] + tvh_pkg::ROUND_K[6'(v[0] + tvh_pkg::rol(v[0], 5'd16))];
        u[3] = v[3] + v[0];
        u[5] = v[5] + v[4] + wn;
        u[6] = v[6] + tvh_pkg::ROUND_K[u[5][5:0]];
        u[7] = tvh_pkg::rol(v[7], 5'd7) + v[4];
        u[4] = ~v[4];
      end
      default: begin
        u[1] = tvh_pkg::rol(v[1], 5'd9);
        u[3] = v[3] + u[1];
        u[5] = tvh_pkg::rol(v[5], 5'd5);
        u[7] = v[7] + u[5];
        u[0] = v[0] + tvh_pkg::ROUND_K[rnd[5:0]] + wn;
        u[2] = v[2] + (u[0] ^ tvh_pkg::rol(u[0], 5'd3) ^ tvh_pkg::rol(u[0], 5'd17));
        u[4] = v[4] + tvh_pkg::ROUND_K[u[3][5:0]] + wn + u[3];
        u[6] = v[6] + u[4];
      end
    endcase
    vn[0] = u[7];
    for (int i = 1; i < 8; i++) vn[i] = u[i - 1];
    for (int i = 0; i < 8; i++) chain_sum[i] = chain[i] + vn[i];
  end

  assign pop                = (state == ST_IDLE) && head_valid;
  assign digest.valid       = (state == ST_EMIT);
  assign digest.digest_word = chain[idx];
  assign digest.word_index  = idx;
  assign digest.last_word   = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && head_valid && head.op == tvh_pkg::OP_ABSORB) begin
      blk[fill[6:2]][31 - 8*fill[1:0] -: 8] <= head.data_byte;
    end
    if (state == ST_COMP) begin
      win[0] <= wn;
      for (int k = 1; k < tvh_pkg::WIN_DEPTH; k++) win[k] <= win[k - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chain     <= tvh_pkg::CHAIN_INIT;
      ch        <= tvh_pkg::CARRY_HIGH_INIT;
      cl        <= tvh_pkg::CARRY_LOW_INIT;
      fill      <= '0;
      len       <= '0;
      cnt       <= '0;
      tail_pend <= 1'b0;
      emit_pend <= 1'b0;
      idx       <= '0;
      rnd       <= '0;
      vsel      <= tvh_pkg::VAR_F;
      mode      <= tvh_pkg::MODE_BUF;
    end else begin
      case (state)
        ST_IDLE: begin
          if (head_valid) begin
            if (head.op == tvh_pkg::OP_ABSORB) begin
              len <= len + 64'd8;
              if (fill == 7'(tvh_pkg::BLOCK_BYTES - 1)) begin
                fill  <= '0;
                vsel  <= vsel_next;
                cnt   <= cnt_next;
                rnd   <= '0;
                v     <= chain;
                mode  <= tvh_pkg::MODE_BUF;
                state <= ST_COMP;
              end else begin
                fill <= fill + 7'd1;
              end
            end else if (len == 64'd0) begin
              idx   <= '0;
              state <= ST_EMIT;
            end else begin
              emit_pend <= 1'b1;
              vsel      <= vsel_next;
              cnt       <= cnt_next;
              rnd       <= '0;
              v         <= chain;
              state     <= ST_COMP;
              if (fill != '0) begin
                fill_save <= fill;
                mode      <= tvh_pkg::MODE_PAD;
                tail_pend <= 1'b1;
              end else begin
                src_h <= ch;
                src_l <= cl;
                ch    <= len[63:32];
                cl    <= len[31:0];
                mode  <= tvh_pkg::MODE_TAIL;
              end
            end
          end
        end
        ST_COMP: begin
          if (rnd == 7'd68) ch <= wn;
          if (rnd == 7'(tvh_pkg::ROUNDS - 1)) begin
            chain <= chain_sum;
            if (tail_pend) begin
              tail_pend <= 1'b0;
              src_h     <= ch;
              src_l     <= wn;
              ch        <= len[63:32];
              cl        <= len[31:0];
              mode      <= tvh_pkg::MODE_TAIL;
              vsel      <= vsel_next;
              cnt       <= cnt_next;
              rnd       <= '0;
              v         <= chain_sum;
            end else begin
              cl  <= wn;
              v   <= vn;
              rnd <= rnd + 7'd1;
              if (emit_pend) begin
                idx   <= '0;
                state <= ST_EMIT;
              end else begin
                state <= ST_IDLE;
              end
            end
          end else begin
            v   <= vn;
            rnd <= rnd + 7'd1;
          end
        end
        ST_EMIT: begin
          if (digest.ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              chain     <= tvh_pkg::CHAIN_INIT;
              ch        <= tvh_pkg::CARRY_HIGH_INIT;
              cl        <= tvh_pkg::CARRY_LOW_INIT;
              fill      <= '0;
              len       <= '0;
              cnt       <= '0;
              emit_pend <= 1'b0;
              state     <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: design/three_variant_hash_256.sv
// Top level of the three-variant 256-bit hash.
// Absorb beat: each byte goes into the block buffer; the 80th byte also starts a block compression.
// Finish: zero, one or two block compressions, then eight digest beats, one per cycle while ready is high.
// Throughput is set by the single shared round unit: one round per cycle.
// A queue of Depth beats lets the feed run ahead while a block is compressed.
// Synchronous reset restores the initial chaining and carry words and empties the queue.
module three_variant_hash_256 #(
  parameter int Depth = 4
) (
  input logic          clk,
  input logic          rst,
  tvh_feed_if.sink     feed,
  tvh_digest_if.source digest
);
  tvh_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  tvh_front #(.Depth(Depth)) u_front (
    .clk(clk), .rst(rst), .feed(feed),
    .head(head), .head_valid(head_valid), .pop(pop)
  );

  tvh_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid),
    .pop(pop), .digest(digest)
  );
endmodule

// File: design/tvh_checker.sv
// Port-level checks on the digest channel, bound to the top level.
module tvh_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(digest_word) && $stable(word_index))
    else $error("digest beat changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    valid && ready && !last_word |=> valid && word_index == $past(word_index) + 3'd1)
    else $error("digest words out of sequence");

  a_rst: assert property (@(posedge clk) rst |=> !valid)
    else $error("digest valid after reset");
endmodule

bind three_variant_hash_256 tvh_checker u_chk (
  .clk(clk), .rst(rst), .valid(digest.valid), .ready(digest.ready),
  .digest_word(digest.digest_word), .word_index(digest.word_index),
  .last_word(digest.last_word)
);

// File: verif/tvh_digest_checker.sv
// Digest predictor and checker for the three-variant hash, watching both channels.
module tvh_digest_checker (
  input  logic  clk,
  input  logic  rst,
  tvh_feed_if   feed,
  tvh_digest_if digest,
  output int    fails,
  output int    pending
);
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0] chain [8];
  logic [31:0] carry_hi, carry_lo;
  logic [7:0]  blk [80];
  int          fill;
  logic [63:0] bit_len;
  logic [31:0] var_count;
  digest_beat_t digest_q[$];

  assign pending = digest_q.size();

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    int s;
    s = n & 31;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic clear_state();
    for (int i = 0; i < 8; i++) chain[i] = tvh_pkg::CHAIN_INIT[i];
    carry_hi = tvh_pkg::CARRY_HIGH_INIT;
    carry_lo = tvh_pkg::CARRY_LOW_INIT;
    for (int i = 0; i < 80; i++) blk[i] = 8'h00;
    fill = 0;
    bit_len = '0;
    var_count = '0;
  endtask

  task automatic compress_block(input int vr);
    logic [31:0] w [70];
    logic [31:0] v [8];
    logic [31:0] t;
    int off;
    off = (vr == 0) ? 0 : (vr == 1) ? 2 : 1;
    for (int n = 0; n < 20; n++)
      w[n + off] = {blk[4*n], blk[4*n+1], blk[4*n+2], blk[4*n+3]};
    if (vr == 0) begin
      w[20] = carry_hi; w[21] = carry_lo;
    end else if (vr == 1) begin
      w[0] = carry_hi; w[1] = carry_lo;
    end else begin
      w[0] = carry_hi; w[21] = carry_lo;
    end
    for (int n = 22; n < 70; n++) begin
      if (vr == 0) begin
        if (n < 46)
          w[n] = rotl32(w[n-1], 7) + (w[n-5] ^ w[n-11] ^ w[n-16]) +
                 rotl32(w[n-22] + w[n-3], 27);
        else
          w[n] = rotl32(w[n-1], 9) + (w[n-6] ^ w[n-16] ^ w[n-31]) +
                 rotl32(w[n-24] + w[n-2], 19);
      end else if (vr == 1) begin
        if (n < 46)
          w[n] = rotl32(w[n-1], 23) + (w[n-3] ^ w[n-7] ^ w[n-18]) +
                 rotl32(w[n-22] + w[n-2], 7);
        else
          w[n] = rotl32(w[n-1], 7) + (w[n-6] ^ w[n-12] ^ w[n-21]) +
                 rotl32(w[n-24] + w[n-2], 27);
      end else begin
        if (n < 46)
          w[n] = rotl32(w[n-2], 29) + (w[n-4] ^ w[n-9] ^ w[n-15]) +
                 rotl32(w[n-22] + w[n-1], 5);
        else
          w[n] = rotl32(w[n-24], 13) + (w[n-5] ^ w[n-10] ^ w[n-19]) +
                 rotl32(w[n-2] + w[n-1], 19);
      end
    end
    carry_hi = w[68];
    carry_lo = w[69];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int n = 0; n < 70; n++) begin
      if (vr == 0) begin
        v[1] += v[0] + w[n];
        v[0] = rotl32(v[0], 3);
        v[2] += tvh_pkg::ROUND_K[v[1][5:0]];
        v[3] += v[0] + (rotl32(v[0], 7) ^ rotl32(v[0], 22));
        v[5] += v[4] + w[n];
        v[6] += tvh_pkg::ROUND_K[w[n][5:0]];
        v[7] += v[4] ^ (rotl32(v[4], 13) + rotl32(v[4], 27));
      end else if (vr == 1) begin
        t = v[0] + rotl32(v[0], 16);
        v[1] += v[0] + w[n];
        v[2] += tvh_pkg::ROUND_K[t[5:0]];
        v[3] += v[0];
        v[5] += v[4] + w[n];
        v[6] += tvh_pkg::ROUND_K[v[5][5:0]];
        v[7] = rotl32(v[7], 7) + v[4];
        v[4] = ~v[4];
      end else begin
        v[1] = rotl32(v[1], 9);
        v[3] += v[1];
        v[5] = rotl32(v[5], 5);
        v[7] += v[5];
        v[0] += tvh_pkg::ROUND_K[n & 63] + w[n];
        v[2] += v[0] ^ rotl32(v[0], 3) ^ rotl32(v[0], 17);
        v[4] += tvh_pkg::ROUND_K[v[3][5:0]] + w[n] + v[3];
        v[6] += v[4];
      end
      t = v[7];
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[0] = t;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic close_block();
    logic [31:0] start;
    logic [31:0] gap;
    start = var_count;
    do var_count++; while (^var_count);
    gap = var_count - start - 1;
    if (gap <= 2) compress_block(gap);
    fill = 0;
  endtask

  task automatic absorb_beat(input logic op, input logic [7:0] b);
    logic [31:0] t;
    if (op == tvh_pkg::OP_ABSORB) begin
      if (fill >= 80) fill = 0;
      blk[fill] = b;
      fill++;
      bit_len += 64'd8;
      if (fill == 80) close_block();
      return;
    end
    if (bit_len != 0) begin
      if (fill != 0) begin
        while (fill < 80) begin
          blk[fill] = 8'h00;
          fill++;
        end
        close_block();
      end
      for (int n = 0; n < 20; n++) begin
        t = rotl32(carry_hi, n) + carry_lo;
        {blk[4*n], blk[4*n+1], blk[4*n+2], blk[4*n+3]} = t;
      end
      carry_hi = bit_len[63:32];
      carry_lo = bit_len[31:0];
      close_block();
    end
    for (int n = 0; n < 8; n++)
      digest_q.push_back('{word: chain[n], index: 3'(n), last: (n == 7)});
    clear_state();
  endtask

  initial begin
    fails = 0;
    clear_state();
  end

  always @(posedge clk) begin
    digest_beat_t exp_b;
    if (rst) begin
      clear_state();
      digest_q.delete();
    end else begin
      if (digest.valid && digest.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat word=%h index=%0d last=%b", $time,
                   digest.digest_word, digest.word_index, digest.last_word);
          fails++;
        end else begin
          exp_b = digest_q.pop_front();
          if (digest.digest_word !== exp_b.word || digest.word_index !== exp_b.index ||
              digest.last_word !== exp_b.last) begin
            $display({"%0t: digest mismatch expected word=%h index=%0d last=%b, ",
                      "got word=%h index=%0d last=%b"},
                     $time, exp_b.word, exp_b.index, exp_b.last,
                     digest.digest_word, digest.word_index, digest.last_word);
            fails++;
          end
        end
      end
      if (feed.valid && feed.ready) absorb_beat(feed.op, feed.data_byte);
    end
  end
endmodule

// File: verif/tb_three_variant_hash_256.sv
// Stimulus and verdict for the three-variant hash testbench.
module tb_three_variant_hash_256;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails, pending;
  int   items;

  tvh_feed_if   feed ();
  tvh_digest_if digest ();

  three_variant_hash_256 dut (.clk(clk), .rst(rst), .feed(feed), .digest(digest));

  tvh_digest_checker chk (.clk(clk), .rst(rst), .feed(feed), .digest(digest),
                          .fails(fails), .pending(pending));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    feed.valid = 1'b0;
    feed.op = tvh_pkg::OP_ABSORB;
    feed.data_byte = 8'h00;
    digest.ready = 1'b0;
  end

  // hold ready low for a random stretch before each beat
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      digest.ready = 1'b0;
      repeat (stall) @(negedge clk);
      digest.ready = 1'b1;
      do @(posedge clk); while (!digest.valid);
      @(negedge clk);
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] b, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      feed.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    feed.valid = 1'b1;
    feed.op = op;
    feed.data_byte = b;
    do @(posedge clk); while (!feed.ready);
    @(negedge clk);
    items++;
  endtask

  task automatic send_message(input int len, input bit burst);
    for (int i = 0; i < len; i++)
      send_beat(tvh_pkg::OP_ABSORB, 8'($urandom_range(0, 255)), burst);
    send_beat(tvh_pkg::OP_FINISH, 8'($urandom_range(0, 255)), burst);
  endtask

  initial begin
    int len;
    bit burst;
    items = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    // empty message, then back-to-back finishes, then one-byte and four-byte messages
    send_beat(tvh_pkg::OP_FINISH, 8'h00, 1'b0);
    send_beat(tvh_pkg::OP_FINISH, 8'hFF, 1'b1);
    send_beat(tvh_pkg::OP_ABSORB, 8'h00, 1'b0);
    send_beat(tvh_pkg::OP_FINISH, 8'h00, 1'b0);
    send_beat(tvh_pkg::OP_ABSORB, 8'hFF, 1'b0);
    send_beat(tvh_pkg::OP_FINISH, 8'hFF, 1'b0);
    send_beat(tvh_pkg::OP_ABSORB, 8'hA5, 1'b1);
    send_beat(tvh_pkg::OP_ABSORB, 8'h5A, 1'b1);
    send_beat(tvh_pkg::OP_ABSORB, 8'h00, 1'b1);
    send_beat(tvh_pkg::OP_ABSORB, 8'hFF, 1'b1);
    send_beat(tvh_pkg::OP_FINISH, 8'h00, 1'b1);
    while (items < 210) begin
      burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0, 1, 2: len = $urandom_range(0, 12);
        3: len = $urandom_range(79, 81);
        4: len = 160;
        default: len = $urandom_range(13, 170);
      endcase
      if (len > 209 - items) len = 209 - items;
      send_message(len, burst);
    end
    feed.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fails == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #600000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
